FILE: sv/csr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csr_pkg: shared types, constants and helpers of the shape rasterizer
// Canvas geometry, command codes, controller states, the control and status
// bundles between controller and datapath, and column mask helpers.
// ----------------------------------------------------------------------------
package csr_pkg;

  // Canvas geometry
  localparam int CANVAS_ROWS = 32;
  localparam int CANVAS_COLS = 64;
  localparam int ROW_W       = (CANVAS_ROWS > 1) ? $clog2(CANVAS_ROWS) : 1;

  // Fixed field widths
  localparam int PIX_W      = 64;
  localparam int COL_IDX_W  = 6;
  localparam int COORD_W    = 10;
  localparam int ROOT_W     = 7;
  localparam int SQ_W       = 2 * ROOT_W;
  localparam int REM_W      = ROOT_W + 1;
  localparam int ROOT_CNT_W = $clog2(ROOT_W + 1);

  typedef logic [PIX_W-1:0]          pix_t;
  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [2:0] {
    MODE_RECT   = 3'd0,
    MODE_LINE   = 3'd1,
    MODE_TRI    = 3'd2,
    MODE_CIRCLE = 3'd3,
    MODE_ERASE  = 3'd4,
    MODE_MOVE   = 3'd5,
    MODE_READ   = 3'd6,
    MODE_CLEAR  = 3'd7
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SWEEP,
    ST_C_SQ,
    ST_C_START,
    ST_C_ROOT,
    ST_C_WR,
    ST_DONE
  } state_e;

  // One command request as captured
  typedef struct packed {
    mode_e      mode;
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] height;
    logic [7:0] width;
    logic [7:0] end_col;
    logic [6:0] radius;
    logic [7:0] new_row;
    logic [7:0] new_col;
    logic [7:0] new_height;
    logic [7:0] new_width;
  } cmd_item_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic row_inc;
    logic pass_set;
    logic row_wr;
    logic sq_load;
    logic root_start;
    logic load_out;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    mode_e mode;
    logic  pass;
    logic  last_row;
    logic  circ_skip;
    logic  root_done;
  } ctl_sts_t;

  function automatic coord_t sx8(logic [7:0] v);
    return {{(COORD_W-8){v[7]}}, v};
  endfunction

  function automatic coord_t zx8(logic [7:0] v);
    return {{(COORD_W-8){1'b0}}, v};
  endfunction

  function automatic logic row_ok(coord_t r);
    return (r >= 0) && (r < coord_t'(CANVAS_ROWS));
  endfunction

  // Columns lo..hi inclusive, clipped to the canvas
  function automatic pix_t span_mask(coord_t lo, coord_t hi);
    coord_t l;
    coord_t h;
    logic [COL_IDX_W-1:0] top_gap;
    l = (lo < 0) ? '0 : lo;
    h = (hi > coord_t'(CANVAS_COLS - 1)) ? coord_t'(CANVAS_COLS - 1) : hi;
    top_gap = COL_IDX_W'(PIX_W - 1) - h[COL_IDX_W-1:0];
    if (l > h) begin
      return '0;
    end
    return ({PIX_W{1'b1}} << l[COL_IDX_W-1:0]) & ({PIX_W{1'b1}} >> top_gap);
  endfunction

endpackage

FILE: sv/csr_cmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csr_cmd_if: command channel of the shape rasterizer
// Valid/ready channel that carries one drawing command per request.
// ----------------------------------------------------------------------------
interface csr_cmd_if;
  logic              valid;
  logic              ready;
  logic [2:0]        mode;
  logic signed [7:0] row;
  logic signed [7:0] col;
  logic [7:0]        height;
  logic [7:0]        width;
  logic signed [7:0] end_col;
  logic [6:0]        radius;
  logic signed [7:0] new_row;
  logic signed [7:0] new_col;
  logic [7:0]        new_height;
  logic [7:0]        new_width;

  modport source (
    output valid, mode, row, col, height, width, end_col, radius,
           new_row, new_col, new_height, new_width,
    input  ready
  );

  modport sink (
    input  valid, mode, row, col, height, width, end_col, radius,
           new_row, new_col, new_height, new_width,
    output ready
  );
endinterface

FILE: sv/csr_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csr_res_if: result channel of the shape rasterizer
// Valid/ready channel that carries one row read result per request.
// ----------------------------------------------------------------------------
interface csr_res_if;
  logic        valid;
  logic        ready;
  logic [63:0] row_pixels;
  logic        row_valid;

  modport source (
    output valid, row_pixels, row_valid,
    input  ready
  );

  modport sink (
    input  valid, row_pixels, row_valid,
    output ready
  );
endinterface

FILE: sv/csr_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csr_isqrt: iterative integer square root
// Digit-by-digit root of a SQ_W-bit value, one result bit per cycle.
// done_o pulses for one cycle once root_o holds the final root.
// ----------------------------------------------------------------------------
module csr_isqrt (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [csr_pkg::SQ_W-1:0] value_i,
  output logic                     done_o,
  output logic [csr_pkg::ROOT_W-1:0] root_o
);
  import csr_pkg::*;

  logic [SQ_W-1:0]       val_q, val_d;
  logic [REM_W-1:0]      rem_q, rem_d;
  logic [ROOT_W-1:0]     root_q, root_d;
  logic [ROOT_CNT_W-1:0] cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [REM_W+1:0]      cur;
  logic [REM_W+1:0]      trial;

  // Bring down the next two bits and try the next root bit
  assign cur   = {rem_q, val_q[SQ_W-1 -: 2]};
  assign trial = (REM_W+2)'({root_q, 2'b01});

  always_comb begin
    val_d  = val_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      val_d  = value_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = ROOT_CNT_W'(ROOT_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      val_d = {val_q[SQ_W-3:0], 2'b00};
      if (cur >= trial) begin
        rem_d  = REM_W'(cur - trial);
        root_d = {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = cur[REM_W-1:0];
        root_d = {root_q[ROOT_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == ROOT_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Hold working values
  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

FILE: sv/csr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csr_dp: rasterizer datapath
// Canvas rows, row sweep counter, per-row span logic, circle half-width
// root and the result register.
// ----------------------------------------------------------------------------
module csr_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  csr_pkg::cmd_item_t    item_i,
  input  csr_pkg::ctl_cmd_t     cmd_i,
  output csr_pkg::ctl_sts_t     sts_o,
  output logic [csr_pkg::PIX_W-1:0] row_pixels_o,
  output logic                  row_valid_o
);
  import csr_pkg::*;

  cmd_item_t         item_q;
  logic [ROW_W-1:0]  cnt_q, cnt_d;
  logic              pass_q, pass_d;
  logic [SQ_W-1:0]   r2_q;
  logic [SQ_W-1:0]   drsq_q;
  pix_t              pix_q;
  logic              vld_q;
  pix_t              canvas_q [CANVAS_ROWS];

  coord_t            r_c;
  coord_t            dr;
  coord_t            absdr;
  logic              skip;
  logic [SQ_W-1:0]   drsq;
  logic [ROOT_W-1:0] root;
  logic              root_done;
  logic              read_ok;
  coord_t            r0, c0, h, w;
  coord_t            tri_i;
  logic              rect_hit;
  logic              hit;
  logic              set;
  coord_t            lo, hi;
  pix_t              mask;
  pix_t              cur;
  pix_t              nxt;

  // Circle row geometry
  assign r_c   = coord_t'(cnt_q);
  assign dr    = r_c - sx8(item_q.row);
  assign absdr = (dr < 0) ? -dr : dr;
  assign skip  = absdr > coord_t'(item_q.radius);
  assign drsq  = SQ_W'(absdr[ROOT_W-1:0]) * SQ_W'(absdr[ROOT_W-1:0]);

  csr_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.root_start),
    .value_i (r2_q - drsq_q),
    .done_o  (root_done),
    .root_o  (root)
  );

  assign read_ok = row_ok(sx8(item_i.row));

  // Select the rectangle of this pass
  always_comb begin
    if (item_q.mode == MODE_MOVE && pass_q) begin
      r0 = sx8(item_q.new_row);
      c0 = sx8(item_q.new_col);
      h  = zx8(item_q.new_height);
      w  = zx8(item_q.new_width);
    end else begin
      r0 = sx8(item_q.row);
      c0 = sx8(item_q.col);
      h  = zx8(item_q.height);
      w  = zx8(item_q.width);
    end
  end

  assign rect_hit = (h != 0) && (w != 0) && (r_c >= r0) && (r_c < r0 + h);
  assign tri_i    = r_c - sx8(item_q.row);

  // Span and operation on the current row
  always_comb begin
    hit = 1'b0;
    set = 1'b1;
    lo  = c0;
    hi  = c0 + w - coord_t'(1);
    case (item_q.mode)
      MODE_RECT: begin
        hit = rect_hit;
      end
      MODE_ERASE: begin
        hit = rect_hit;
        set = 1'b0;
      end
      MODE_MOVE: begin
        hit = rect_hit;
        set = pass_q;
      end
      MODE_LINE: begin
        hit = (r_c == sx8(item_q.row)) && (sx8(item_q.end_col) >= sx8(item_q.col));
        lo  = sx8(item_q.col);
        hi  = sx8(item_q.end_col);
      end
      MODE_TRI: begin
        hit = (tri_i >= 0) && (tri_i < zx8(item_q.height));
        lo  = sx8(item_q.col);
        hi  = sx8(item_q.col) + tri_i;
      end
      MODE_CIRCLE: begin
        hit = 1'b1;
        lo  = sx8(item_q.col) - coord_t'(root);
        hi  = sx8(item_q.col) + coord_t'(root);
      end
      MODE_CLEAR: begin
        hit = 1'b1;
        set = 1'b0;
        lo  = '0;
        hi  = coord_t'(CANVAS_COLS - 1);
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  end

  assign mask = span_mask(lo, hi);
  assign cur  = canvas_q[cnt_q];
  assign nxt  = set ? (cur | mask) : (cur & ~mask);

  // Advance the row counter and move pass
  always_comb begin
    cnt_d  = cnt_q;
    pass_d = pass_q;
    if (cmd_i.capture) begin
      cnt_d  = (item_i.mode == MODE_READ && read_ok) ? item_i.row[ROW_W-1:0] : '0;
      pass_d = 1'b0;
    end else if (cmd_i.pass_set) begin
      cnt_d  = '0;
      pass_d = 1'b1;
    end else if (cmd_i.row_inc) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      pass_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      pass_q <= pass_d;
    end
  end

  // Update the canvas one row at a time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CANVAS_ROWS; i++) begin
        canvas_q[i] <= '0;
      end
    end else if (cmd_i.row_wr && hit) begin
      canvas_q[cnt_q] <= nxt;
    end
  end

  // Latch the request, radius squared, row distance squared and result
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= item_i;
      r2_q   <= SQ_W'(item_i.radius) * SQ_W'(item_i.radius);
    end
    if (cmd_i.sq_load) begin
      drsq_q <= drsq;
    end
    if (cmd_i.load_out) begin
      vld_q <= (item_q.mode == MODE_READ) && row_ok(sx8(item_q.row));
      pix_q <= ((item_q.mode == MODE_READ) && row_ok(sx8(item_q.row))) ? cur : '0;
    end
  end

  assign sts_o.mode      = item_q.mode;
  assign sts_o.pass      = pass_q;
  assign sts_o.last_row  = (cnt_q == ROW_W'(CANVAS_ROWS - 1));
  assign sts_o.circ_skip = skip;
  assign sts_o.root_done = root_done;

  assign row_pixels_o = pix_q;
  assign row_valid_o  = vld_q;

endmodule

FILE: sv/csr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csr_ctrl: rasterizer controller
// Sequences the row sweeps of each command, the per-row circle steps and
// the hand-off of the result into the output register.
// ----------------------------------------------------------------------------
module csr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  logic              res_ready_i,
  output logic              res_valid_o,
  input  csr_pkg::ctl_sts_t sts_i,
  output csr_pkg::ctl_cmd_t cmd_o
);
  import csr_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (sts_i.mode)
          MODE_READ:   state_d = ST_DONE;
          MODE_CIRCLE: state_d = ST_C_SQ;
          default:     state_d = ST_SWEEP;
        endcase
      end
      ST_SWEEP: begin
        cmd_o.row_wr = 1'b1;
        if (sts_i.last_row) begin
          if (sts_i.mode == MODE_MOVE && !sts_i.pass) begin
            cmd_o.pass_set = 1'b1;
          end else begin
            state_d = ST_DONE;
          end
        end else begin
          cmd_o.row_inc = 1'b1;
        end
      end
      ST_C_SQ: begin
        if (sts_i.circ_skip) begin
          if (sts_i.last_row) begin
            state_d = ST_DONE;
          end else begin
            cmd_o.row_inc = 1'b1;
          end
        end else begin
          cmd_o.sq_load = 1'b1;
          state_d       = ST_C_START;
        end
      end
      ST_C_START: begin
        cmd_o.root_start = 1'b1;
        state_d          = ST_C_ROOT;
      end
      ST_C_ROOT: begin
        if (sts_i.root_done) begin
          state_d = ST_C_WR;
        end
      end
      ST_C_WR: begin
        cmd_o.row_wr = 1'b1;
        if (sts_i.last_row) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.row_inc = 1'b1;
          state_d       = ST_C_SQ;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || res_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold the result until it is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign res_valid_o = out_valid_q;

endmodule

FILE: sv/canvas_shape_rasterizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// canvas_shape_rasterizer: one-bit-per-pixel canvas with shape commands
// Draws rectangles, lines, triangles and filled circles, erases and moves
// rectangles, clears the canvas and reads back single rows.
// ----------------------------------------------------------------------------
//  channel  dir  modport  payload
//  cmd_i    in   sink     mode, row, col, height, width, end_col, radius,
//                         new_row, new_col, new_height, new_width
//  res_o    out  source   row_pixels, row_valid (one result per request)
//
// One request at a time; the canvas is swept one row per cycle, but a circle
// row inside the radius passes the square, root start, square root and write
// states. Rect, line, triangle, erase and clear sweep once, move sweeps twice
// (erase pass, then draw pass), and a read sweeps no rows.
// Reset clears the canvas at once; the next request is taken while an
// earlier result still waits in the output register.
// ----------------------------------------------------------------------------
module canvas_shape_rasterizer (
  input  logic clk_i,
  input  logic rst_ni,
  csr_cmd_if.sink   cmd_i,
  csr_res_if.source res_o
);
  import csr_pkg::*;

  cmd_item_t item;
  ctl_cmd_t  ctl_cmd;
  ctl_sts_t  ctl_sts;

  // Pack the request
  assign item.mode       = mode_e'(cmd_i.mode);
  assign item.row        = cmd_i.row;
  assign item.col        = cmd_i.col;
  assign item.height     = cmd_i.height;
  assign item.width      = cmd_i.width;
  assign item.end_col    = cmd_i.end_col;
  assign item.radius     = cmd_i.radius;
  assign item.new_row    = cmd_i.new_row;
  assign item.new_col    = cmd_i.new_col;
  assign item.new_height = cmd_i.new_height;
  assign item.new_width  = cmd_i.new_width;

  csr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_i.valid),
    .cmd_ready_o (cmd_i.ready),
    .res_ready_i (res_o.ready),
    .res_valid_o (res_o.valid),
    .sts_i       (ctl_sts),
    .cmd_o       (ctl_cmd)
  );

  csr_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .cmd_i        (ctl_cmd),
    .sts_o        (ctl_sts),
    .row_pixels_o (res_o.row_pixels),
    .row_valid_o  (res_o.row_valid)
  );

endmodule

FILE: test/canvas_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// canvas_checker: canvas predictor and result checker of the rasterizer
// Watches the command and result channels. Each accepted command request is
// drawn on a private copy of the canvas, and the row read it yields is
// queued. Each accepted result is compared against the oldest queued read.
// ----------------------------------------------------------------------------
module canvas_checker (
  input  logic clk_i,
  input  logic rst_ni,
  csr_cmd_if   cmd_mon_i,
  csr_res_if   res_mon_i,
  output int   mismatch_cnt_o,
  output int   pending_cnt_o
);
  import csr_pkg::*;

  typedef struct packed {
    pix_t pixels;
    logic row_valid;
  } row_read_t;

  pix_t      canvas_bits [CANVAS_ROWS];
  row_read_t row_read_q [$];
  int        mismatch_cnt = 0;

  assign mismatch_cnt_o = mismatch_cnt;

  function automatic bit on_canvas(int r);
    return (r >= 0) && (r < CANVAS_ROWS);
  endfunction

  // Build the mask of columns lo..hi, clipped to the canvas
  function automatic pix_t col_span(int lo, int hi);
    int l;
    int h;
    l = (lo < 0) ? 0 : lo;
    h = (hi > CANVAS_COLS - 1) ? CANVAS_COLS - 1 : hi;
    if (l > h) begin
      return '0;
    end
    return ({PIX_W{1'b1}} >> (PIX_W - 1 - (h - l))) << l;
  endfunction

  // Set or clear a clipped rectangle
  function automatic void paint_box(int r0, int c0, int h, int w, bit set_px);
    pix_t m;
    if (h <= 0 || w <= 0) begin
      return;
    end
    m = col_span(c0, c0 + w - 1);
    for (int r = r0; r < r0 + h; r++) begin
      if (on_canvas(r)) begin
        if (set_px) begin
          canvas_bits[r] = canvas_bits[r] | m;
        end else begin
          canvas_bits[r] = canvas_bits[r] & ~m;
        end
      end
    end
  endfunction

  function automatic void blank_canvas();
    for (int r = 0; r < CANVAS_ROWS; r++) begin
      canvas_bits[r] = '0;
    end
  endfunction

  // Apply one command to the canvas and return the row read it yields
  function automatic row_read_t draw_command(cmd_item_t c);
    row_read_t rd;
    int        r;
    int        cl;
    int        ec;
    int        nr;
    int        nc;
    int        rad_sq;
    int        dr;
    int        dc;
    r      = $signed(c.row);
    cl     = $signed(c.col);
    ec     = $signed(c.end_col);
    nr     = $signed(c.new_row);
    nc     = $signed(c.new_col);
    rad_sq = int'(c.radius) * int'(c.radius);
    rd     = '0;
    case (c.mode)
      MODE_RECT: begin
        paint_box(r, cl, int'(c.height), int'(c.width), 1'b1);
      end
      MODE_LINE: begin
        if (on_canvas(r) && ec >= cl) begin
          canvas_bits[r] = canvas_bits[r] | col_span(cl, ec);
        end
      end
      MODE_TRI: begin
        for (int i = 0; i < int'(c.height); i++) begin
          if (on_canvas(r + i)) begin
            canvas_bits[r + i] = canvas_bits[r + i] | col_span(cl, cl + i);
          end
        end
      end
      MODE_CIRCLE: begin
        for (int i = 0; i < CANVAS_ROWS; i++) begin
          for (int j = 0; j < CANVAS_COLS; j++) begin
            dr = i - r;
            dc = j - cl;
            if (dr * dr + dc * dc <= rad_sq) begin
              canvas_bits[i][j] = 1'b1;
            end
          end
        end
      end
      MODE_ERASE: begin
        paint_box(r, cl, int'(c.height), int'(c.width), 1'b0);
      end
      MODE_MOVE: begin
        paint_box(r, cl, int'(c.height), int'(c.width), 1'b0);
        paint_box(nr, nc, int'(c.new_height), int'(c.new_width), 1'b1);
      end
      MODE_READ: begin
        if (on_canvas(r)) begin
          rd.pixels    = canvas_bits[r];
          rd.row_valid = 1'b1;
        end
      end
      default: begin
        blank_canvas();
      end
    endcase
    return rd;
  endfunction

  // Check results first, then predict for a command accepted at this edge
  always @(posedge clk_i or negedge rst_ni) begin
    cmd_item_t cap;
    row_read_t exp_rd;
    if (!rst_ni) begin
      blank_canvas();
      row_read_q.delete();
    end else begin
      if (res_mon_i.valid && res_mon_i.ready) begin
        if (row_read_q.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: unexpected result: expected none, actual pixels %h valid %b",
                   $time, res_mon_i.row_pixels, res_mon_i.row_valid);
        end else begin
          exp_rd = row_read_q.pop_front();
          if (res_mon_i.row_pixels !== exp_rd.pixels) begin
            mismatch_cnt++;
            $display("%0t: row_pixels mismatch: expected %h actual %h",
                     $time, exp_rd.pixels, res_mon_i.row_pixels);
          end
          if (res_mon_i.row_valid !== exp_rd.row_valid) begin
            mismatch_cnt++;
            $display("%0t: row_valid mismatch: expected %b actual %b",
                     $time, exp_rd.row_valid, res_mon_i.row_valid);
          end
        end
      end
      if (cmd_mon_i.valid && cmd_mon_i.ready) begin
        cap.mode       = mode_e'(cmd_mon_i.mode);
        cap.row        = cmd_mon_i.row;
        cap.col        = cmd_mon_i.col;
        cap.height     = cmd_mon_i.height;
        cap.width      = cmd_mon_i.width;
        cap.end_col    = cmd_mon_i.end_col;
        cap.radius     = cmd_mon_i.radius;
        cap.new_row    = cmd_mon_i.new_row;
        cap.new_col    = cmd_mon_i.new_col;
        cap.new_height = cmd_mon_i.new_height;
        cap.new_width  = cmd_mon_i.new_width;
        row_read_q.push_back(draw_command(cap));
      end
    end
    pending_cnt_o = row_read_q.size();
  end

endmodule

FILE: test/tb_canvas_shape_rasterizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_canvas_shape_rasterizer: stimulus and verdict for the shape rasterizer
// Sends a directed set of drawing commands and reads, then random commands
// in phases of sender idling and receiver stalls, including a long receiver
// hold-off and a full drain. The checker beside the block predicts results.
// ----------------------------------------------------------------------------
module tb_canvas_shape_rasterizer;
  import csr_pkg::*;

  localparam int PHASE_ITEMS  = 500;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 400;

  logic clk_i;
  logic rst_ni;
  int   send_idle_pct;
  int   recv_stall_pct;
  bit   hold_req;
  int   hold_left;
  int   mismatch_cnt;
  int   pending_cnt;

  csr_cmd_if cmd_if ();
  csr_res_if res_if ();

  canvas_shape_rasterizer u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .res_o  (res_if)
  );

  canvas_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_mon_i      (cmd_if),
    .res_mon_i      (res_if),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_cnt_o  (pending_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Drive result ready: long hold-off on request, else random stalls
  initial begin
    res_if.ready = 1'b0;
    hold_left    = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready = 1'b0;
      end else if (hold_req) begin
        hold_req     = 1'b0;
        hold_left    = HOLD_CYCLES;
        res_if.ready = 1'b0;
      end else begin
        res_if.ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offer one request after a random gap and hold it until accepted
  task automatic push_cmd(cmd_item_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
    end
    cmd_if.mode       = c.mode;
    cmd_if.row        = c.row;
    cmd_if.col        = c.col;
    cmd_if.height     = c.height;
    cmd_if.width      = c.width;
    cmd_if.end_col    = c.end_col;
    cmd_if.radius     = c.radius;
    cmd_if.new_row    = c.new_row;
    cmd_if.new_col    = c.new_col;
    cmd_if.new_height = c.new_height;
    cmd_if.new_width  = c.new_width;
    cmd_if.valid      = 1'b1;
    do begin
      @(posedge clk_i);
    end while (!cmd_if.ready);
    @(negedge clk_i);
    cmd_if.valid = 1'b0;
  endtask

  task automatic send(mode_e m, int r, int c, int h, int w, int ec, int rad,
                      int nr = 0, int nc = 0, int nh = 0, int nw = 0);
    cmd_item_t it;
    it.mode       = m;
    it.row        = 8'(r);
    it.col        = 8'(c);
    it.height     = 8'(h);
    it.width      = 8'(w);
    it.end_col    = 8'(ec);
    it.radius     = 7'(rad);
    it.new_row    = 8'(nr);
    it.new_col    = 8'(nc);
    it.new_height = 8'(nh);
    it.new_width  = 8'(nw);
    push_cmd(it);
  endtask

  task automatic wait_drained();
    while (pending_cnt != 0) begin
      @(negedge clk_i);
    end
  endtask

  function automatic int near_row();
    return int'($urandom_range(47)) - 8;
  endfunction

  function automatic int near_col();
    return int'($urandom_range(79)) - 8;
  endfunction

  // Mostly commands near the canvas; some with every field fully random
  function automatic cmd_item_t random_cmd();
    cmd_item_t it;
    int        pick;
    int        c;
    pick = $urandom_range(99);
    c    = near_col();
    it.row        = 8'(near_row());
    it.col        = 8'(c);
    it.height     = 8'($urandom_range(40));
    it.width      = 8'($urandom_range(40));
    it.end_col    = 8'(c + int'($urandom_range(45)) - 5);
    it.radius     = ($urandom_range(4) == 0) ? 7'($urandom_range(40))
                                             : 7'($urandom_range(12));
    it.new_row    = 8'(near_row());
    it.new_col    = 8'(near_col());
    it.new_height = 8'($urandom_range(40));
    it.new_width  = 8'($urandom_range(40));
    if (pick < 30) begin
      it.mode = MODE_READ;
    end else if (pick < 40) begin
      it.mode = MODE_RECT;
    end else if (pick < 52) begin
      it.mode = MODE_LINE;
    end else if (pick < 62) begin
      it.mode = MODE_TRI;
    end else if (pick < 70) begin
      it.mode = MODE_CIRCLE;
    end else if (pick < 84) begin
      it.mode = MODE_ERASE;
    end else if (pick < 96) begin
      it.mode = MODE_MOVE;
    end else begin
      it.mode = MODE_CLEAR;
    end
    if ($urandom_range(9) == 0) begin
      it.mode       = mode_e'($urandom_range(7));
      it.row        = 8'($urandom);
      it.col        = 8'($urandom);
      it.height     = 8'($urandom);
      it.width      = 8'($urandom);
      it.end_col    = 8'($urandom);
      it.radius     = 7'($urandom);
      it.new_row    = 8'($urandom);
      it.new_col    = 8'($urandom);
      it.new_height = 8'($urandom);
      it.new_width  = 8'($urandom);
    end
    return it;
  endfunction

  initial begin
    cmd_if.valid      = 1'b0;
    cmd_if.mode       = '0;
    cmd_if.row        = '0;
    cmd_if.col        = '0;
    cmd_if.height     = '0;
    cmd_if.width      = '0;
    cmd_if.end_col    = '0;
    cmd_if.radius     = '0;
    cmd_if.new_row    = '0;
    cmd_if.new_col    = '0;
    cmd_if.new_height = '0;
    cmd_if.new_width  = '0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    hold_req          = 1'b0;
    rst_ni            = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: blank read, full fill, clipping and empty shapes
    send(MODE_READ, 0, 0, 0, 0, 0, 0);
    send(MODE_RECT, -128, -128, 255, 255, 0, 0);
    send(MODE_READ, 31, 0, 0, 0, 0, 0);
    send(MODE_CLEAR, 0, 0, 0, 0, 0, 0);
    send(MODE_READ, 5, 0, 0, 0, 0, 0);
    send(MODE_RECT, 0, 0, 0, 5, 0, 0);
    send(MODE_RECT, 1, 0, 5, 0, 0, 0);
    send(MODE_LINE, 3, -5, 0, 0, 70, 0);
    send(MODE_LINE, 4, 10, 0, 0, 5, 0);
    send(MODE_READ, 3, 0, 0, 0, 0, 0);
    send(MODE_READ, 4, 0, 0, 0, 0, 0);
    send(MODE_TRI, -3, 60, 10, 0, 0, 0);
    send(MODE_READ, 5, 0, 0, 0, 0, 0);
    send(MODE_CIRCLE, -128, -128, 0, 0, 0, 127);
    send(MODE_CIRCLE, 10, 10, 0, 0, 0, 5);
    send(MODE_CIRCLE, 16, 32, 0, 0, 0, 0);
    send(MODE_READ, 10, 0, 0, 0, 0, 0);
    send(MODE_ERASE, 8, 8, 5, 5, 0, 0);
    send(MODE_READ, 10, 0, 0, 0, 0, 0);
    send(MODE_MOVE, 2, 55, 20, 20, 0, 0, 20, 50, 20, 20);
    send(MODE_READ, 25, 0, 0, 0, 0, 0);
    send(MODE_READ, -1, 0, 0, 0, 0, 0);
    send(MODE_READ, 32, 0, 0, 0, 0, 0);
    send(MODE_READ, 127, 0, 0, 0, 0, 0);
    send(MODE_READ, -128, 0, 0, 0, 0, 0);
    wait_drained();

    // Random phases; pause for a full drain before each
    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_req       = 1'b1;
        end
        1: begin
          send_idle_pct  = 82;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 82;
        end
        default: begin
          send_idle_pct  = 15;
          recv_stall_pct = 15;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        push_cmd(random_cmd());
      end
    end

    // Drain and settle
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: sim.f
sv/csr_pkg.sv
sv/csr_cmd_if.sv
sv/csr_res_if.sv
sv/csr_isqrt.sv
sv/csr_dp.sv
sv/csr_ctrl.sv
sv/canvas_shape_rasterizer.sv
test/canvas_checker.sv
test/tb_canvas_shape_rasterizer.sv
